// ----- rtl/dpalu_pkg.sv -----
// shared types and codes for the data-processing alu
package dpalu_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } t_alu_op;

    typedef enum logic [3:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'hA,
        COND_LT = 4'hB,
        COND_GT = 4'hC,
        COND_LE = 4'hD,
        COND_AL = 4'hE,
        COND_NV = 4'hF
    } t_cond;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    localparam logic [3:0]  REG_PC     = 4'hF;
    localparam logic [31:0] PC_AHEAD   = 32'd4;
    localparam logic [7:0]  WORD_BITS  = 8'd32;

    typedef struct packed {
        logic        condition_passed;
        logic [31:0] result_value;
        logic        write_destination;
        logic [3:0]  destination_index;
        logic        negative;
        logic        zero;
        logic        carry;
        logic        overflow;
        logic        branch_taken;
        logic        restore_status;
    } t_result;

endpackage

// ----- rtl/data_processing_alu_top.sv -----
// execute stage of an armv4 data-processing instruction: barrel shifter, alu and flags
//
// data_processing_alu_top takes one instruction word with its operand values and the
// current nzcv flags, and returns one result word: condition pass, alu result,
// destination write enable and index, new flags, pc write and status restore. the
// condition field is checked against the incoming flags; a failed condition gives a
// zero result, no writes and the flags unchanged. operand 2 is a rotated 8-bit
// immediate or rm shifted by an immediate or by the low byte of rs, with the usual
// shifter carry rules (rrx, shift by 32 and above). with a register-specified shift,
// rn or rm naming the pc read 4 higher, and that add is folded in ahead of the input
// register. compares with s clear write nothing and leave the flags alone. a word
// accepted into the input register moves on to the result register, which drives
// o_valid, once the result side can take it (input register, then result register);
// one word is accepted every cycle unless both registers are full and the result is
// held, with the shifter and 32-bit adder path between the two registers setting the
// clock. a held result stalls the input side only when both registers are full.
module data_processing_alu_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_first_operand,
    input  logic [31:0] i_shifted_operand,
    input  logic [7:0]  i_shift_register_byte,
    input  logic        i_negative_in,
    input  logic        i_zero_in,
    input  logic        i_carry_in,
    input  logic        i_overflow_in,
    input  logic        i_privileged,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_condition_passed,
    output logic [31:0] o_result_value,
    output logic        o_write_destination,
    output logic [3:0]  o_destination_index,
    output logic        o_negative_out,
    output logic        o_zero_out,
    output logic        o_carry_out,
    output logic        o_overflow_out,
    output logic        o_branch_taken,
    output logic        o_restore_status
);
    import dpalu_pkg::*;

    // input register
    logic        r_s1_valid;
    logic [31:0] r_ins;
    logic [31:0] r_a;
    logic [31:0] r_m;
    logic [7:0]  r_sb;
    logic        r_n;
    logic        r_z;
    logic        r_c;
    logic        r_v;
    logic        r_priv;

    // result register
    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;

    logic        s2_ready;
    logic        in_take;

    // pc-relative read adjust for register-specified shifts
    logic        reg_shift_in;
    logic [31:0] n_a;
    logic [31:0] n_m;

    // decode
    t_alu_op     op;
    t_cond       cond;
    t_shift      sh_kind;
    logic        s_bit;
    logic        by_reg;
    logic [3:0]  rd;
    logic        pass;

    // operand 2
    logic [31:0] op2;
    logic        sh_carry;

    // alu
    logic [31:0] alu_res;
    logic        add_carry;
    logic        add_ovf;
    logic        logical;
    logic        is_cmp;

    // ---------------------------------------------------------------- handshake
    // two-register pipeline; the input stage refills whenever its word moves on
    assign s2_ready = !r_out_valid || i_ready;
    assign o_ready  = !r_s1_valid || s2_ready;
    assign in_take  = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ---------------------------------------------------------------- input stage
    assign reg_shift_in = !i_instruction[25] && i_instruction[4];
    assign n_a = (reg_shift_in && (i_instruction[19:16] == REG_PC))
                 ? i_first_operand + PC_AHEAD : i_first_operand;
    assign n_m = (reg_shift_in && (i_instruction[3:0] == REG_PC))
                 ? i_shifted_operand + PC_AHEAD : i_shifted_operand;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ins  <= i_instruction;
            r_a    <= n_a;
            r_m    <= n_m;
            r_sb   <= i_shift_register_byte;
            r_n    <= i_negative_in;
            r_z    <= i_zero_in;
            r_c    <= i_carry_in;
            r_v    <= i_overflow_in;
            r_priv <= i_privileged;
        end
    end

    // ---------------------------------------------------------------- decode
    assign op      = t_alu_op'(r_ins[24:21]);
    assign cond    = t_cond'(r_ins[31:28]);
    assign sh_kind = t_shift'(r_ins[6:5]);
    assign s_bit   = r_ins[20];
    assign by_reg  = r_ins[4];
    assign rd      = r_ins[15:12];

    always_comb begin
        unique case (cond)
            COND_EQ: pass = r_z;
            COND_NE: pass = !r_z;
            COND_CS: pass = r_c;
            COND_CC: pass = !r_c;
            COND_MI: pass = r_n;
            COND_PL: pass = !r_n;
            COND_VS: pass = r_v;
            COND_VC: pass = !r_v;
            COND_HI: pass = r_c && !r_z;
            COND_LS: pass = !r_c || r_z;
            COND_GE: pass = (r_n == r_v);
            COND_LT: pass = (r_n != r_v);
            COND_GT: pass = !r_z && (r_n == r_v);
            COND_LE: pass = r_z || (r_n != r_v);
            COND_AL: pass = 1'b1;
            COND_NV: pass = 1'b0;
            default: pass = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- barrel shifter
    always_comb begin
        logic [63:0]        imm_dbl;
        logic [4:0]         imm_rot;
        logic [7:0]         sh_amt;
        logic [4:0]         amt5;
        logic               under32;
        logic               is32;
        logic [32:0]        lsl_ext;
        logic [32:0]        lsr_ext;
        logic signed [32:0] asr_ext;
        logic [63:0]        ror_dbl;

        imm_rot = {r_ins[11:8], 1'b0};
        imm_dbl = {24'd0, r_ins[7:0], 24'd0, r_ins[7:0]} >> imm_rot;
        sh_amt  = by_reg ? r_sb : {3'd0, r_ins[11:7]};
        amt5    = sh_amt[4:0];
        under32 = (sh_amt[7:5] == 3'd0);
        is32    = (sh_amt == WORD_BITS);
        lsl_ext = {1'b0, r_m} << amt5;
        lsr_ext = {r_m, 1'b0} >> amt5;
        asr_ext = $signed({r_m, 1'b0}) >>> amt5;
        ror_dbl = {r_m, r_m} >> amt5;

        op2      = r_m;
        sh_carry = r_c;
        if (r_ins[25]) begin
            // rotated immediate, carry only changes on a nonzero rotate
            op2      = imm_dbl[31:0];
            sh_carry = (imm_rot != 5'd0) ? imm_dbl[31] : r_c;
        end else if (!by_reg && (sh_amt == 8'd0)) begin
            // immediate amount zero: lsl #0, lsr #32, asr #32, rrx
            unique case (sh_kind)
                SH_LSL: begin
                    op2      = r_m;
                    sh_carry = r_c;
                end
                SH_LSR: begin
                    op2      = 32'd0;
                    sh_carry = r_m[31];
                end
                SH_ASR: begin
                    op2      = {32{r_m[31]}};
                    sh_carry = r_m[31];
                end
                SH_ROR: begin
                    op2      = {r_c, r_m[31:1]};
                    sh_carry = r_m[0];
                end
                default: begin
                    op2      = r_m;
                    sh_carry = r_c;
                end
            endcase
        end else if (sh_amt == 8'd0) begin
            op2      = r_m;
            sh_carry = r_c;
        end else begin
            unique case (sh_kind)
                SH_LSL: begin
                    if (under32) begin
                        op2      = lsl_ext[31:0];
                        sh_carry = lsl_ext[32];
                    end else begin
                        op2      = 32'd0;
                        sh_carry = is32 && r_m[0];
                    end
                end
                SH_LSR: begin
                    if (under32) begin
                        op2      = lsr_ext[32:1];
                        sh_carry = lsr_ext[0];
                    end else begin
                        op2      = 32'd0;
                        sh_carry = is32 && r_m[31];
                    end
                end
                SH_ASR: begin
                    if (under32) begin
                        op2      = asr_ext[32:1];
                        sh_carry = asr_ext[0];
                    end else begin
                        op2      = {32{r_m[31]}};
                        sh_carry = r_m[31];
                    end
                end
                SH_ROR: begin
                    op2      = ror_dbl[31:0];
                    sh_carry = ror_dbl[31];
                end
                default: begin
                    op2      = r_m;
                    sh_carry = r_c;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- alu
    always_comb begin
        logic [31:0] x;
        logic [31:0] y;
        logic        cin;
        logic        sub;
        logic [32:0] sum;

        x       = r_a;
        y       = op2;
        cin     = 1'b0;
        sub     = 1'b1;
        logical = 1'b1;
        alu_res = 32'd0;
        unique case (op)
            OP_AND, OP_TST: alu_res = r_a & op2;
            OP_EOR, OP_TEQ: alu_res = r_a ^ op2;
            OP_ORR:         alu_res = r_a | op2;
            OP_MOV:         alu_res = op2;
            OP_BIC:         alu_res = r_a & ~op2;
            OP_MVN:         alu_res = ~op2;
            OP_SUB, OP_CMP: begin
                logical = 1'b0;
                cin     = 1'b1;
            end
            OP_RSB: begin
                logical = 1'b0;
                x       = op2;
                y       = r_a;
                cin     = 1'b1;
            end
            OP_ADD, OP_CMN: begin
                logical = 1'b0;
                sub     = 1'b0;
            end
            OP_ADC: begin
                logical = 1'b0;
                sub     = 1'b0;
                cin     = r_c;
            end
            OP_SBC: begin
                logical = 1'b0;
                cin     = r_c;
            end
            OP_RSC: begin
                logical = 1'b0;
                x       = op2;
                y       = r_a;
                cin     = r_c;
            end
            default: alu_res = 32'd0;
        endcase
        if (sub) begin
            y = ~y;
        end
        sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
        add_carry = sum[32];
        add_ovf   = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
        if (!logical) begin
            alu_res = sum[31:0];
        end
    end

    assign is_cmp = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);

    // ---------------------------------------------------------------- result assembly
    always_comb begin
        n_res = '{
            condition_passed:  pass,
            result_value:      32'd0,
            write_destination: 1'b0,
            destination_index: rd,
            negative:          r_n,
            zero:              r_z,
            carry:             r_c,
            overflow:          r_v,
            branch_taken:      1'b0,
            restore_status:    1'b0
        };
        if (pass) begin
            n_res.result_value      = alu_res;
            n_res.write_destination = !is_cmp;
            n_res.branch_taken      = !is_cmp && (rd == REG_PC);
            if (s_bit) begin
                n_res.negative       = alu_res[31];
                n_res.zero           = (alu_res == 32'd0);
                n_res.carry          = logical ? sh_carry : add_carry;
                n_res.overflow       = logical ? r_v : add_ovf;
                n_res.restore_status = (rd == REG_PC) && r_priv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_res <= n_res;
        end
    end

    assign o_condition_passed  = r_res.condition_passed;
    assign o_result_value      = r_res.result_value;
    assign o_write_destination = r_res.write_destination;
    assign o_destination_index = r_res.destination_index;
    assign o_negative_out      = r_res.negative;
    assign o_zero_out          = r_res.zero;
    assign o_carry_out         = r_res.carry;
    assign o_overflow_out      = r_res.overflow;
    assign o_branch_taken      = r_res.branch_taken;
    assign o_restore_status    = r_res.restore_status;

`ifndef SYNTH
    // a pc write always goes through the destination port with rd = 15
    a_branch_is_pc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_branch_taken |-> o_write_destination && (o_destination_index == REG_PC))
        else $error("branch without pc write");

    // a failed condition writes nothing and leaves a zero result
    a_fail_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_condition_passed |->
            !o_write_destination && !o_branch_taken && !o_restore_status &&
            (o_result_value == 32'd0))
        else $error("failed condition produced side effects");

    // status restore needs a passed condition and the pc as destination
    a_restore_needs_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_restore_status |-> o_condition_passed && (o_destination_index == REG_PC))
        else $error("status restore without pc destination");

    // a word held in the input register is not dropped while the result side stalls
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_ins))
        else $error("input register lost a word under stall");
`endif

endmodule
